/* hw/rtl/cmns_pkg.sv */
// ----------------------------------------------------------------------------
// cmns_pkg: shared types and constants of the cube map nearest sampler
// Field layouts of request and response transfers, register indexes,
// face codes, divider transfers, sequencer states and the size clamp.
// ----------------------------------------------------------------------------
package cmns_pkg;

	localparam int MAX_FACE_DIM = 128;
	localparam int FACE_COUNT   = 6;

	localparam int COORD_W = $clog2(MAX_FACE_DIM);
	localparam int SIZE_W  = $clog2(MAX_FACE_DIM + 1);
	localparam int FACE_W  = 3;
	localparam int COLOR_W = 8;
	localparam int TEXEL_W = 3 * COLOR_W;
	localparam int DIR_W   = 16;
	localparam int COMP_W  = DIR_W + 1;
	localparam int MAJ_W   = DIR_W;
	localparam int BASE_W  = MAJ_W + 1;
	localparam int DEN_W   = MAJ_W + 1;
	localparam int PROD_W  = BASE_W + SIZE_W;
	localparam int QUOT_W  = SIZE_W;

	// quotient-bit steps of the coordinate unit and its step counter
	localparam int DIV_STEPS = QUOT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int STORE_DEPTH  = FACE_COUNT * MAX_FACE_DIM * MAX_FACE_DIM;
	localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 8'd128;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	typedef struct packed {
		logic                     action;
		logic [FACE_W-1:0]        face_sel;
		logic [COORD_W-1:0]       texel_col;
		logic [COORD_W-1:0]       texel_row;
		logic [COLOR_W-1:0]       in_red;
		logic [COLOR_W-1:0]       in_green;
		logic [COLOR_W-1:0]       in_blue;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic signed [DIR_W-1:0]  dir_z;
	} req_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic [FACE_W-1:0]  face_hit;
		logic [COORD_W-1:0] hit_col;
		logic [COORD_W-1:0] hit_row;
		logic               zero_direction;
	} rsp_item_t;

	// divider launch and its answer
	typedef struct packed {
		logic              start;
		logic [BASE_W-1:0] base;
		logic [MAJ_W-1:0]  major;
		logic [SIZE_W-1:0] size;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] coord;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LAUNCH_U,
		ST_WAIT_U,
		ST_LAUNCH_V,
		ST_WAIT_V,
		ST_READ,
		ST_FINISH
	} seq_state_t;

	// zero reads as one, anything above the largest face as the largest face
	function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
		logic [SIZE_W-1:0] s;
		if (r == '0) begin
			s = SIZE_W'(1);
		end else if (CFG_W'(r) > CFG_W'(MAX_FACE_DIM)) begin
			s = SIZE_W'(MAX_FACE_DIM);
		end else begin
			s = SIZE_W'(r);
		end
		return s;
	endfunction

endpackage

/* hw/rtl/cube_map_nearest_sampler.sv */
// ----------------------------------------------------------------------------
// cube_map_nearest_sampler: six-face RGB cube map, nearest texel lookup
// Stores texels written over the request channel and answers sample
// requests with the texel that a direction vector points at.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries two kinds of
//   transfer. A write stores one 24-bit texel in the cycle it is taken and
//   gives no response; the next request is taken in the following cycle.
//   A sample picks the major-axis face, works out column and row, reads the
//   texel and sends one response transfer (rsp_valid / rsp_stall / rsp_data).
//   A sample goes from request to response in these steps: the column and
//   the row each go through the one shared coordinate unit (a multiply and
//   eight quotient bits, plus launch and handoff), then one texel store
//   read. req_stall stays high while a sample is in flight, so the next
//   sample is taken only after the previous response is loaded. An all-zero
//   direction skips the arithmetic and answers black.
//   The response sits in an output register; while the receiver stalls it
//   holds steady, and the block keeps taking writes. A later sample waits at
//   its last step until the register drains.
//   Face size registers (wr_en / wr_index / wr_data) reset to 128; the user
//   changes them only when idle (unenforced). Reset clears control and sizes
//   but not the texel store; texels must be written before they are sampled.
// ----------------------------------------------------------------------------
module cube_map_nearest_sampler import cmns_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_item_t            req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_item_t            rsp_data,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	// configuration
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_SIZE_RESET;
			height_q <= CFG_SIZE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_FACE_WIDTH:  width_q  <= wr_data;
				REG_FACE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic [SIZE_W-1:0] eff_w;
	logic [SIZE_W-1:0] eff_h;
	assign eff_w = eff_size(width_q);
	assign eff_h = eff_size(height_q);

	// sequencer
	seq_state_t state_q;
	seq_state_t state_next;

	logic req_take;
	logic sample_take;
	logic rsp_free;
	logic rsp_load;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign req_take    = req_valid && !req_stall;
	assign sample_take = req_take && (req_data.action == ACT_SAMPLE);
	assign rsp_free    = !rsp_valid || !rsp_stall;

	// sample working registers
	logic signed [DIR_W-1:0] dir_x_q;
	logic signed [DIR_W-1:0] dir_y_q;
	logic signed [DIR_W-1:0] dir_z_q;
	logic [FACE_W-1:0]       face_q;
	logic [MAJ_W-1:0]        major_q;
	logic [BASE_W-1:0]       base_u_q;
	logic [BASE_W-1:0]       base_v_q;
	logic                    zero_q;
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;

	// face selection from the held direction; y is flipped before use
	logic signed [COMP_W-1:0] cx;
	logic signed [COMP_W-1:0] cy;
	logic signed [COMP_W-1:0] cz;
	logic [MAJ_W-1:0]         ax;
	logic [MAJ_W-1:0]         ay;
	logic [MAJ_W-1:0]         az;
	logic signed [COMP_W-1:0] uc;
	logic signed [COMP_W-1:0] vc;
	logic [MAJ_W-1:0]         major;
	logic [FACE_W-1:0]        face;
	logic                     zero_dir;
	logic signed [COMP_W:0]   sum_u;
	logic signed [COMP_W:0]   sum_v;

	always_comb begin
		logic signed [COMP_W-1:0] nx;
		logic signed [COMP_W-1:0] ny;
		logic signed [COMP_W-1:0] nz;
		cx = COMP_W'(dir_x_q);
		cy = -COMP_W'(dir_y_q);
		cz = COMP_W'(dir_z_q);
		nx = -cx;
		ny = -cy;
		nz = -cz;
		ax = (cx < 0) ? nx[MAJ_W-1:0] : cx[MAJ_W-1:0];
		ay = (cy < 0) ? ny[MAJ_W-1:0] : cy[MAJ_W-1:0];
		az = (cz < 0) ? nz[MAJ_W-1:0] : cz[MAJ_W-1:0];
		zero_dir = (ax == '0) && (ay == '0) && (az == '0);

		major = '0;
		uc    = '0;
		vc    = '0;
		face  = FACE_PX;
		// later tests override earlier ones on ties: Z over Y over X
		if (ax >= ay && ax >= az) begin
			major = ax;
			vc    = cy;
			if (cx > 0) begin
				uc   = nz;
				face = FACE_PX;
			end else begin
				uc   = cz;
				face = FACE_NX;
			end
		end
		if (ay >= ax && ay >= az) begin
			major = ay;
			uc    = cx;
			if (cy > 0) begin
				vc   = nz;
				face = FACE_PY;
			end else begin
				vc   = cz;
				face = FACE_NY;
			end
		end
		if (az >= ax && az >= ay) begin
			major = az;
			vc    = cy;
			if (cz > 0) begin
				uc   = cx;
				face = FACE_PZ;
			end else begin
				uc   = nx;
				face = FACE_NZ;
			end
		end
		// minor + major lies in 0 .. 2*major
		sum_u = (COMP_W+1)'(uc) + $signed({2'b00, major});
		sum_v = (COMP_W+1)'(vc) + $signed({2'b00, major});
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:     if (sample_take) state_next = ST_SETUP;
			ST_SETUP:    state_next = zero_dir ? ST_FINISH : ST_LAUNCH_U;
			ST_LAUNCH_U: state_next = ST_WAIT_U;
			ST_WAIT_U:   if (div_rsp.done) state_next = ST_LAUNCH_V;
			ST_LAUNCH_V: state_next = ST_WAIT_V;
			ST_WAIT_V:   if (div_rsp.done) state_next = ST_READ;
			ST_READ:     state_next = ST_FINISH;
			ST_FINISH:   if (rsp_free) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	// sequencer outputs
	logic ram_re;

	always_comb begin
		req_stall     = (state_q != ST_IDLE);
		div_req.start = (state_q == ST_LAUNCH_U) || (state_q == ST_LAUNCH_V);
		div_req.major = major_q;
		div_req.base  = (state_q == ST_LAUNCH_V) ? base_v_q : base_u_q;
		div_req.size  = (state_q == ST_LAUNCH_V) ? eff_h : eff_w;
		ram_re        = (state_q == ST_READ);
		rsp_load      = (state_q == ST_FINISH) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// hold the direction, then the face and both coordinate numerators
	always_ff @(posedge clk) begin
		if (sample_take) begin
			dir_x_q <= req_data.dir_x;
			dir_y_q <= req_data.dir_y;
			dir_z_q <= req_data.dir_z;
		end
		if (state_q == ST_SETUP) begin
			zero_q   <= zero_dir;
			face_q   <= face;
			major_q  <= major;
			base_u_q <= sum_u[BASE_W-1:0];
			base_v_q <= sum_v[BASE_W-1:0];
		end
		if (state_q == ST_WAIT_U && div_rsp.done) begin
			col_q <= div_rsp.coord;
		end
		if (state_q == ST_WAIT_V && div_rsp.done) begin
			row_q <= div_rsp.coord;
		end
	end

	cmns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// texel store: address is face, row, column laid end to end
	logic                    ram_we;
	logic [STORE_ADDR_W-1:0] ram_waddr;
	logic [STORE_ADDR_W-1:0] ram_raddr;
	logic [TEXEL_W-1:0]      ram_wdata;
	logic [TEXEL_W-1:0]      ram_rdata;

	// drop writes aimed past the last face
	assign ram_we    = req_take && (req_data.action == ACT_WRITE) &&
	                   (req_data.face_sel < FACE_W'(FACE_COUNT));
	assign ram_waddr = STORE_ADDR_W'({req_data.face_sel, req_data.texel_row,
	                                  req_data.texel_col});
	assign ram_wdata = {req_data.in_red, req_data.in_green, req_data.in_blue};
	assign ram_raddr = STORE_ADDR_W'({face_q, row_q, col_q});

	cmns_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// response register: load when empty or draining, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (zero_q) begin
				// black on face zero, texel zero, flagged
				rsp_data.out_red        <= '0;
				rsp_data.out_green      <= '0;
				rsp_data.out_blue       <= '0;
				rsp_data.face_hit       <= FACE_PX;
				rsp_data.hit_col        <= '0;
				rsp_data.hit_row        <= '0;
				rsp_data.zero_direction <= 1'b1;
			end else begin
				rsp_data.out_red        <= ram_rdata[TEXEL_W-1 -: COLOR_W];
				rsp_data.out_green      <= ram_rdata[COLOR_W +: COLOR_W];
				rsp_data.out_blue       <= ram_rdata[COLOR_W-1:0];
				rsp_data.face_hit       <= face_q;
				rsp_data.hit_col        <= col_q;
				rsp_data.hit_row        <= row_q;
				rsp_data.zero_direction <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/cmns_ram.sv */
// ----------------------------------------------------------------------------
// cmns_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cmns_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/cmns_div.sv */
// ----------------------------------------------------------------------------
// cmns_div: shared texel coordinate unit
// Computes floor(base * size / (2 * major)), wrapping a result equal to size
// to zero: a multiply, then one restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmns_div import cmns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 mul_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BASE_W-1:0]    base_q;
	logic [SIZE_W-1:0]    size_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [QUOT_W-1:0]    lo_q;
	logic [QUOT_W-1:0]    quot_q;

	logic [PROD_W-1:0] prod;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic [DEN_W-1:0]  rem_next;

	assign prod     = PROD_W'(base_q) * PROD_W'(size_q);
	assign trial    = {rem_q, lo_q[QUOT_W-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_next = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			mul_q  <= req.start;
			if (mul_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			base_q <= req.base;
			size_q <= req.size;
			den_q  <= {req.major, 1'b0};
		end
		// high part of the product is already below the divisor
		if (mul_q) begin
			rem_q <= prod[PROD_W-1:QUOT_W];
			lo_q  <= prod[QUOT_W-1:0];
		end else if (run_q) begin
			rem_q  <= rem_next;
			lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.coord = (quot_q == QUOT_W'(size_q)) ? '0 : quot_q[COORD_W-1:0];

endmodule

/* hw/rtl/cmns_checker.sv */
// ----------------------------------------------------------------------------
// cmns_checker: port-level checks of the cube map nearest sampler
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cmns_checker import cmns_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input req_item_t            req_data,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input rsp_item_t            rsp_data
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// a sample occupies the block: no second request the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.action == ACT_SAMPLE |=> req_stall)
		else $error("request taken right after a sample");

	// zero direction answers black on face zero, texel zero
	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.zero_direction |->
		rsp_data.out_red == '0 && rsp_data.out_green == '0 &&
		rsp_data.out_blue == '0 && rsp_data.face_hit == FACE_PX &&
		rsp_data.hit_col == '0 && rsp_data.hit_row == '0)
		else $error("zero direction response not black");

	// only six faces exist
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.face_hit != 3'd6 && rsp_data.face_hit != 3'd7)
		else $error("response names a face that does not exist");

endmodule

bind cube_map_nearest_sampler cmns_checker u_cmns_checker (.*);
